/* rtl/sss_pkg.sv */
`timescale 1ns / 1ps

package sss_pkg;

    localparam int PERIOD_W        = 7;
    localparam int STEP_W          = 6;
    localparam int DEF_MAX_PERIOD  = 64;
    localparam int DEF_COORD_BITS  = 16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture an input item
        logic row_start;  // begin the row sweep for the current candidate step
        logic b_step;     // advance one lattice row
        logic decide;     // score the candidate, move to the next one
        logic prod;       // form col + step*row
        logic mod_step;   // one bit of the remainder
        logic out_load;   // move the result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic search_done;  // no candidate left, or simple mode already has its step
        logic b_last;       // last row of the sweep
        logic mod_last;     // last remainder bit
    } t_sts;

endpackage

/* rtl/satin_step_search_core.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_period, i_simple_mode, i_col, i_row
// output    out        o_out_valid / i_out_stall   o_step, o_on_tie
//
// one item at a time; a full search over period p tries the candidate steps 2 to p-2,
// one lattice row per cycle for each candidate step, then reduces col + step*row mod p
// bit-serially and loads the result once the output register is free
// simple mode stops after the first coprime step
// the output register holds a result under stall while the next item is accepted
// reset is synchronous, active low, and clears the controller and the valid flags

module satin_step_search_core
    import sss_pkg::*;
#(
    parameter int MAX_PERIOD = DEF_MAX_PERIOD,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PERIOD_W-1:0]   i_period,
    input  logic                  i_simple_mode,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STEP_W-1:0]     o_step,
    output logic                  o_on_tie
);

    t_cmd cmd;
    t_sts sts;

    sss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sss_dp #(
        .MAX_PERIOD (MAX_PERIOD),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_period      (i_period),
        .i_simple_mode (i_simple_mode),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_step        (o_step),
        .o_on_tie      (o_on_tie)
    );

    // an accepted transfer starts work and closes the input
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input still open after a transfer");

    // the controller issues at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // a result never overwrites one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output register overwritten under stall");

    // a new result comes only from the controller's final state
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.out_load))
        else $error("output valid without a result load");

endmodule

/* rtl/sss_ctrl.sv */
`timescale 1ns / 1ps

module sss_ctrl
    import sss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROW,
        ST_DRAIN,
        ST_DECIDE,
        ST_PROD,
        ST_MOD,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.search_done) begin
                    n_state = ST_PROD;
                end else begin
                    o_cmd.row_start = 1'b1;
                    n_state         = ST_ROW;
                end
            end
            ST_ROW: begin
                o_cmd.b_step = 1'b1;
                if (i_sts.b_last) begin
                    n_state = ST_DRAIN;
                end
            end
            // last row length is compared at this edge
            ST_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_CHECK;
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = ST_MOD;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/sss_dp.sv */
`timescale 1ns / 1ps

module sss_dp
    import sss_pkg::*;
#(
    parameter int MAX_PERIOD = DEF_MAX_PERIOD,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [PERIOD_W-1:0]   i_period,
    input  logic                  i_simple_mode,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [STEP_W-1:0]     o_step,
    output logic                  o_on_tie
);

    localparam int PW   = $clog2(MAX_PERIOD + 1);
    localparam int EW   = (PW > PERIOD_W) ? PW : PERIOD_W;
    localparam int LW   = 2 * PW + 1;
    localparam int SUMW = COORD_BITS + PW + 1;
    localparam int CNTW = $clog2(SUMW);

    logic [PW-1:0]         r_p, r_s, r_b, r_a, r_best;
    logic                  r_simple, r_cop;
    logic [COORD_BITS-1:0] r_col, r_row;
    logic [LW-1:0]         r_len, r_short, r_best_len;
    logic                  r_len_vld;
    logic [SUMW-1:0]       r_sum;
    logic [PW-1:0]         r_rem;
    logic [CNTW-1:0]       r_cnt;
    logic [STEP_W-1:0]     r_step_o;
    logic                  r_tie_o;

    logic [EW-1:0]  per_ext;
    logic [PW-1:0]  p_in;
    logic [PW-1:0]  da;
    logic [LW-1:0]  len;
    logic [PW:0]    a_sum;
    logic [PW-1:0]  a_next;
    logic [PW:0]    rem2;
    logic [PW:0]    rem_sub;
    logic           take;

    // period 0 acts as 1, large periods clamp to the maximum
    always_comb begin
        per_ext = EW'(i_period);
        if (per_ext == '0) begin
            p_in = PW'(1);
        end else if (per_ext > EW'(MAX_PERIOD)) begin
            p_in = PW'(MAX_PERIOD);
        end else begin
            p_in = PW'(per_ext);
        end
    end

    // wrapped distance of the residue s*b mod p
    assign da  = (r_a < (r_p - r_a)) ? r_a : (r_p - r_a);
    assign len = LW'(da) * LW'(da) + LW'(r_b) * LW'(r_b);

    assign a_sum  = {1'b0, r_a} + {1'b0, r_s};
    assign a_next = (a_sum >= {1'b0, r_p}) ? PW'(a_sum - {1'b0, r_p}) : PW'(a_sum);

    assign rem2    = {r_rem, r_sum[SUMW-1]};
    assign rem_sub = (rem2 >= {1'b0, r_p}) ? (rem2 - {1'b0, r_p}) : rem2;

    assign take = r_cop && (r_short > r_best_len) && (!r_simple || (r_best_len == '0));

    assign o_sts.search_done = (({1'b0, r_s} + (PW + 1)'(2)) > {1'b0, r_p})
                               || (r_simple && (r_best_len != '0));
    assign o_sts.b_last      = (r_b == (r_p - PW'(1)));
    assign o_sts.mod_last    = (r_cnt == '0);

    assign o_step   = r_step_o;
    assign o_on_tie = r_tie_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= 1'b0;
        end else begin
            r_len_vld <= i_cmd.b_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p        <= p_in;
            r_simple   <= i_simple_mode;
            r_col      <= i_col;
            r_row      <= i_row;
            r_s        <= PW'(2);
            r_best     <= PW'(1);
            r_best_len <= '0;
        end
        if (i_cmd.row_start) begin
            r_b     <= PW'(1);
            r_a     <= r_s;
            r_cop   <= 1'b1;
            r_short <= LW'(r_p) * LW'(r_p);
        end
        if (i_cmd.b_step) begin
            // a zero residue before row p means the step shares a factor with p
            if (r_a == '0) begin
                r_cop <= 1'b0;
            end
            r_len <= len;
            r_b   <= r_b + PW'(1);
            r_a   <= a_next;
        end
        if (r_len_vld && (r_len < r_short)) begin
            r_short <= r_len;
        end
        if (i_cmd.decide) begin
            if (take) begin
                r_best     <= r_s;
                r_best_len <= r_short;
            end
            r_s <= r_s + PW'(1);
        end
        if (i_cmd.prod) begin
            r_sum <= SUMW'(r_col) + SUMW'(r_best) * SUMW'(r_row);
            r_rem <= '0;
            r_cnt <= CNTW'(SUMW - 1);
        end
        // restoring remainder, msb first
        if (i_cmd.mod_step) begin
            r_rem <= PW'(rem_sub);
            r_sum <= {r_sum[SUMW-2:0], 1'b0};
            r_cnt <= r_cnt - CNTW'(1);
        end
        if (i_cmd.out_load) begin
            r_step_o <= STEP_W'(r_best);
            r_tie_o  <= (r_rem == '0);
        end
    end

endmodule
